### rtl/tmdsp_pkg.sv
// Shared types and constants for the touch min-delta sample picker.
`timescale 1ns / 1ps
`default_nettype none
package tmdsp_pkg;

    localparam int unsigned SAMPLE_W      = 12;
    localparam int unsigned OPCODE_W      = 2;
    localparam int unsigned SLOT_OUT_W    = 3;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned CFG_DATA_W    = 1;
    localparam int unsigned FILTER_DEPTH_DEF = 8;

    // Differences are kept in a 13-bit code: bit 12 set marks the
    // "first sample" region 0xFFFFF000..0xFFFFFFFF (low bits = offset),
    // bit 12 clear holds an in-burst delta of at most 4095.
    localparam int unsigned DIFF_W = SAMPLE_W + 1;
    localparam logic [DIFF_W-1:0] DIFF_INIT = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE   = 2'd0,
        OP_END_THR  = 2'd1,
        OP_END_NOTH = 2'd2
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_Y = 1'b1;

endpackage
`default_nettype wire

### rtl/touch_min_delta_sample_picker_unit.sv
// Top level of the touch min-delta sample picker.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  input    | i_valid / o_stall          | i_opcode, i_sample_x, i_sample_y
//  output   | o_valid / i_stall          | o_pos_x, o_pos_y, o_slot, o_slot_written,
//           |                            | o_pressed
//  config   | i_cfg_we                   | i_cfg_idx, i_cfg_wdata
//
// One item per cycle while o_stall is low. A sample item updates the picker
// state in the cycle it is accepted; an interrupt-end item shows its result in
// the output register on the next cycle. The output register is the only stage,
// so input stalls only while that register holds an item and the sink stalls.
// Synchronous active-low reset initialises the control state, but not the result
// payload; ignore countdown loads FILTER_DEPTH. Opcode 3 is dropped without effect.
`timescale 1ns / 1ps
`default_nettype none
module touch_min_delta_sample_picker_unit #(
    parameter int unsigned FILTER_DEPTH = tmdsp_pkg::FILTER_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [tmdsp_pkg::OPCODE_W-1:0]      i_opcode,
    input  wire logic [tmdsp_pkg::SAMPLE_W-1:0]      i_sample_x,
    input  wire logic [tmdsp_pkg::SAMPLE_W-1:0]      i_sample_y,
    // output channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [tmdsp_pkg::SAMPLE_W-1:0]           o_pos_x,
    output logic [tmdsp_pkg::SAMPLE_W-1:0]           o_pos_y,
    output logic [tmdsp_pkg::SLOT_OUT_W-1:0]         o_slot,
    output logic                                     o_slot_written,
    output logic                                     o_pressed,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [tmdsp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tmdsp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int unsigned SW     = tmdsp_pkg::SAMPLE_W;
    localparam int unsigned DW     = tmdsp_pkg::DIFF_W;
    localparam int unsigned SLOT_W = $clog2(FILTER_DEPTH);
    localparam int unsigned IGN_W  = $clog2(FILTER_DEPTH + 1);
    localparam logic [SLOT_W:0]    SLOT_LAST = (SLOT_W + 1)'(FILTER_DEPTH);
    localparam logic [IGN_W-1:0]   IGN_INIT  = IGN_W'(FILTER_DEPTH);

    // configuration
    logic r_invert_x, r_invert_y;

    // picker state
    logic              r_in_burst,   n_in_burst;
    logic [SW-1:0]     r_last_x,     n_last_x;
    logic [SW-1:0]     r_last_y,     n_last_y;
    logic [DW-1:0]     r_best_x,     n_best_x;
    logic [DW-1:0]     r_best_y,     n_best_y;
    logic [SW-1:0]     r_chosen_x,   n_chosen_x;
    logic [SW-1:0]     r_chosen_y,   n_chosen_y;
    logic [SLOT_W-1:0] r_ring,       n_ring;
    logic [IGN_W-1:0]  r_ignore,     n_ignore;
    logic              r_press,      n_press;

    // output register
    logic              r_valid,      n_valid;
    logic [SW-1:0]     r_pos_x,      n_pos_x;
    logic [SW-1:0]     r_pos_y,      n_pos_y;
    logic [tmdsp_pkg::SLOT_OUT_W-1:0] r_slot, n_slot;
    logic              r_written,    n_written;
    logic              r_pressed,    n_pressed;

    logic              accept;
    tmdsp_pkg::t_opcode op;
    logic [DW-1:0]     diff_x, diff_y;
    logic [SLOT_W:0]   ring_inc;
    logic [SLOT_W+tmdsp_pkg::SLOT_OUT_W-1:0] slot_ext;

    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    assign op      = tmdsp_pkg::t_opcode'(i_opcode);

    // First sample of a burst sits in the high region: 0xFFFFFFFF - v.
    // Later samples give a small absolute delta.
    function automatic logic [DW-1:0] delta(input logic first, input logic [SW-1:0] v,
                                            input logic [SW-1:0] prev);
        logic [DW-1:0] res;
        if (first) begin
            res = {1'b1, ~v};
        end else if (v > prev) begin
            res = {1'b0, v - prev};
        end else begin
            res = {1'b0, prev - v};
        end
        return res;
    endfunction

    assign diff_x   = delta(~r_in_burst, i_sample_x, r_last_x);
    assign diff_y   = delta(~r_in_burst, i_sample_y, r_last_y);
    assign ring_inc = {1'b0, r_ring} + 1'b1;
    assign slot_ext = {{tmdsp_pkg::SLOT_OUT_W{1'b0}}, r_ring};

    always_comb begin
        n_in_burst = r_in_burst;
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_best_x   = r_best_x;
        n_best_y   = r_best_y;
        n_chosen_x = r_chosen_x;
        n_chosen_y = r_chosen_y;
        n_ring     = r_ring;
        n_ignore   = r_ignore;
        n_press    = r_press;
        n_valid    = r_valid & i_stall;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_slot     = r_slot;
        n_written  = r_written;
        n_pressed  = r_pressed;

        if (accept) begin
            unique case (op)
                tmdsp_pkg::OP_SAMPLE: begin
                    if (diff_x < r_best_x) begin
                        n_best_x   = diff_x;
                        n_chosen_x = i_sample_x;
                    end
                    if (diff_y < r_best_y) begin
                        n_best_y   = diff_y;
                        n_chosen_y = i_sample_y;
                    end
                    n_last_x   = i_sample_x;
                    n_last_y   = i_sample_y;
                    n_in_burst = 1'b1;
                end
                tmdsp_pkg::OP_END_THR, tmdsp_pkg::OP_END_NOTH: begin
                    if (op == tmdsp_pkg::OP_END_THR) begin
                        n_ring = (ring_inc >= SLOT_LAST) ? '0 : ring_inc[SLOT_W-1:0];
                    end
                    n_in_burst = 1'b0;
                    n_best_x   = tmdsp_pkg::DIFF_INIT;
                    n_best_y   = tmdsp_pkg::DIFF_INIT;
                    if (r_ignore == '0) begin
                        n_press = 1'b1;
                    end else begin
                        n_ignore = r_ignore - 1'b1;
                    end
                    // inversion 4095 - v is a bitwise complement on 12 bits
                    n_valid   = 1'b1;
                    n_pos_x   = r_invert_x ? ~r_chosen_x : r_chosen_x;
                    n_pos_y   = r_invert_y ? ~r_chosen_y : r_chosen_y;
                    n_slot    = slot_ext[tmdsp_pkg::SLOT_OUT_W-1:0];
                    n_written = (op == tmdsp_pkg::OP_END_THR);
                    n_pressed = n_press;
                end
                default: begin
                    // opcode 3: no effect
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_x <= 1'b0;
            r_invert_y <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tmdsp_pkg::CFG_INVERT_X: r_invert_x <= i_cfg_wdata[0];
                tmdsp_pkg::CFG_INVERT_Y: r_invert_y <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_burst <= 1'b0;
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_best_x   <= tmdsp_pkg::DIFF_INIT;
            r_best_y   <= tmdsp_pkg::DIFF_INIT;
            r_chosen_x <= '0;
            r_chosen_y <= '0;
            r_ring     <= '0;
            r_ignore   <= IGN_INIT;
            r_press    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_in_burst <= n_in_burst;
            r_last_x   <= n_last_x;
            r_last_y   <= n_last_y;
            r_best_x   <= n_best_x;
            r_best_y   <= n_best_y;
            r_chosen_x <= n_chosen_x;
            r_chosen_y <= n_chosen_y;
            r_ring     <= n_ring;
            r_ignore   <= n_ignore;
            r_press    <= n_press;
            r_valid    <= n_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_pos_x   <= n_pos_x;
        r_pos_y   <= n_pos_y;
        r_slot    <= n_slot;
        r_written <= n_written;
        r_pressed <= n_pressed;
    end

    assign o_valid        = r_valid;
    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_slot         = r_slot;
    assign o_slot_written = r_written;
    assign o_pressed      = r_pressed;

endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the touch min-delta sample picker unit.
`timescale 1ns / 1ps
module tb_top;
    import tmdsp_pkg::*;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int unsigned DEPTH = FILTER_DEPTH_DEF;
    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;   // dropped by the block
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hFFF;
    localparam int PHASE_ITEMS = 106;
    localparam int SETTLE_CYCLES = 8;     // settle margin for a one-stage block
    localparam int MAX_MISMATCH_LINES = 40;

    // Register settings of the random phases, bit p belongs to phase p.
    // Phase 3 also runs without any idling on either side.
    localparam int NUM_PHASES = 5;
    localparam bit [NUM_PHASES-1:0] FLIP_X_BY_PHASE = 5'b10011;
    localparam bit [NUM_PHASES-1:0] FLIP_Y_BY_PHASE = 5'b10101;
    localparam int BUSY_PHASE = 3;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] y;
    } touch_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   pos_x;
        logic [SAMPLE_W-1:0]   pos_y;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  slot_written;
        logic                  pressed;
    } touch_report_t;

    // ------------------------------------------------------------------
    // DUT signals, driven inputs all known from time zero
    // ------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [OPCODE_W-1:0]    i_opcode = OP_SAMPLE;
    logic [SAMPLE_W-1:0]    i_sample_x = '0;
    logic [SAMPLE_W-1:0]    i_sample_y = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [SAMPLE_W-1:0]    o_pos_x;
    logic [SAMPLE_W-1:0]    o_pos_y;
    logic [SLOT_OUT_W-1:0]  o_slot;
    logic                   o_slot_written;
    logic                   o_pressed;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    touch_min_delta_sample_picker_unit #(
        .FILTER_DEPTH(DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_opcode(i_opcode),
        .i_sample_x(i_sample_x),
        .i_sample_y(i_sample_y),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_pos_x(o_pos_x),
        .o_pos_y(o_pos_y),
        .o_slot(o_slot),
        .o_slot_written(o_slot_written),
        .o_pressed(o_pressed),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Queues and bookkeeping
    // ------------------------------------------------------------------
    touch_item_t   touch_feed[$];         // items waiting to be driven
    touch_report_t expected_reports[$];   // predicted reports, oldest first
    int            fail_count = 0;
    bit            idle_on = 1'b1;        // random gaps/stalls enabled
    int            send_gap = 0;
    int            stall_left = 0;

    // ------------------------------------------------------------------
    // Predictor state: mirrors the picker's registers
    // ------------------------------------------------------------------
    bit                 flip_x = 1'b0;
    bit                 flip_y = 1'b0;
    bit                 burst_open = 1'b0;
    logic [SAMPLE_W-1:0] prev_x = '0;
    logic [SAMPLE_W-1:0] prev_y = '0;
    logic [31:0]        best_dx = '1;
    logic [31:0]        best_dy = '1;
    logic [SAMPLE_W-1:0] pick_x = '0;
    logic [SAMPLE_W-1:0] pick_y = '0;
    int unsigned        ring_pos = 0;
    int unsigned        holdoff_left = DEPTH;
    bit                 press_seen = 1'b0;

    function automatic logic [31:0] distance(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Advance the picker model by one accepted item; interrupt ends queue a report.
    task automatic track_touch(input touch_item_t it);
        touch_report_t rep;
        logic [31:0]   dx;
        logic [31:0]   dy;
        // first sample of a burst is measured against all ones
        dx = distance({20'd0, it.x}, burst_open ? {20'd0, prev_x} : 32'hFFFF_FFFF);
        dy = distance({20'd0, it.y}, burst_open ? {20'd0, prev_y} : 32'hFFFF_FFFF);
        case (it.op)
            OP_SAMPLE: begin
                if (dx < best_dx) begin
                    best_dx = dx;
                    pick_x  = it.x;
                end
                if (dy < best_dy) begin
                    best_dy = dy;
                    pick_y  = it.y;
                end
                prev_x     = it.x;
                prev_y     = it.y;
                burst_open = 1'b1;
            end
            OP_END_THR, OP_END_NOTH: begin
                rep.slot         = ring_pos[SLOT_OUT_W-1:0];
                rep.slot_written = (it.op == OP_END_THR);
                if (it.op == OP_END_THR) begin
                    ring_pos = (ring_pos + 1 >= DEPTH) ? 0 : ring_pos + 1;
                end
                burst_open = 1'b0;
                best_dx    = '1;
                best_dy    = '1;
                // ignore countdown: press only once it has run out
                if (holdoff_left == 0) begin
                    press_seen = 1'b1;
                end else begin
                    holdoff_left--;
                end
                rep.pos_x   = flip_x ? FULL_SCALE - pick_x : pick_x;
                rep.pos_y   = flip_y ? FULL_SCALE - pick_y : pick_y;
                rep.pressed = press_seen;
                expected_reports.push_back(rep);
            end
            default: begin
                // reserved opcode: no effect at all
            end
        endcase
    endtask

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents items from touch_feed, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                track_touch('{op: i_opcode, x: i_sample_x, y: i_sample_y});
            end
            // payload and valid only move when nothing is held
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (touch_feed.size() != 0) begin
                    i_opcode   <= touch_feed[0].op;
                    i_sample_x <= touch_feed[0].x;
                    i_sample_y <= touch_feed[0].y;
                    void'(touch_feed.pop_front());
                    i_valid    <= 1'b1;
                    send_gap   = pause_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stalls on the report side, checks each report
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        touch_report_t got;
        touch_report_t want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{pos_x: o_pos_x, pos_y: o_pos_y, slot: o_slot,
                        slot_written: o_slot_written, pressed: o_pressed};
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_MISMATCH_LINES)
                        $display("%0t: unexpected report x=%0d y=%0d slot=%0d wr=%0b pr=%0b",
                                 $time, got.pos_x, got.pos_y, got.slot,
                                 got.slot_written, got.pressed);
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_MISMATCH_LINES)
                            $display({"%0t: report mismatch: expected x=%0d y=%0d slot=%0d ",
                                      "wr=%0b pr=%0b, actual x=%0d y=%0d slot=%0d wr=%0b pr=%0b"},
                                     $time, want.pos_x, want.pos_y, want.slot,
                                     want.slot_written, want.pressed, got.pos_x, got.pos_y,
                                     got.slot, got.slot_written, got.pressed);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall    <= 1'b0;
                stall_left = pause_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic feed(input logic [OPCODE_W-1:0] op, input logic [SAMPLE_W-1:0] x,
                        input logic [SAMPLE_W-1:0] y);
        touch_feed.push_back('{op: op, x: x, y: y});
    endtask

    // Register write; only called while the block is idle.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_INVERT_X) flip_x = val[0];
        else flip_y = val[0];
    endtask

    // Sender holds off until every report is back, then lets the block settle
    // (sample items leave nothing to wait for).
    task automatic settle();
        do @(negedge i_clk);
        while (touch_feed.size() != 0 || i_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return FULL_SCALE;
        return SAMPLE_W'($urandom);
    endfunction

    // Sample near a burst's base point, with the odd glitch thrown in.
    function automatic logic [SAMPLE_W-1:0] jitter(input logic [SAMPLE_W-1:0] base);
        int v;
        if ($urandom_range(0, 4) == 0) return rand_coord();
        v = int'(base) + $urandom_range(0, 12) - 6;
        if (v < 0) v = 0;
        if (v > int'(FULL_SCALE)) v = FULL_SCALE;
        return SAMPLE_W'(v);
    endfunction

    // Well-formed bursts with random content; reserved opcodes as noise.
    task automatic queue_phase(input int target);
        int made;
        int len;
        logic [SAMPLE_W-1:0] bx;
        logic [SAMPLE_W-1:0] by;
        made = 0;
        while (made < target) begin
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            bx  = rand_coord();
            by  = rand_coord();
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 19) == 0)
                    feed(OP_RESERVED, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                feed(OP_SAMPLE, jitter(bx), jitter(by));
            end
            feed(($urandom_range(0, 9) < 7) ? OP_END_THR : OP_END_NOTH,
                 SAMPLE_W'($urandom), SAMPLE_W'($urandom));
            made += len + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_setting(CFG_INVERT_X, 1'b0);
        write_setting(CFG_INVERT_Y, 1'b0);

        @(negedge i_clk);
        // empty burst right after reset: pair is still zero
        feed(OP_END_NOTH, 12'h000, 12'h000);
        // zero as first sample is never picked; extremes next
        feed(OP_SAMPLE, 12'h000, 12'h000);
        feed(OP_SAMPLE, FULL_SCALE, FULL_SCALE);
        feed(OP_SAMPLE, FULL_SCALE, 12'h000);   // x delta 0, y delta ties (kept)
        feed(OP_END_THR, 12'hFFF, 12'hFFF);
        // lone first sample is picked; reserved opcode in between changes nothing
        feed(OP_SAMPLE, FULL_SCALE, 12'h001);
        feed(OP_RESERVED, 12'hABC, 12'h543);
        feed(OP_RESERVED, 12'hFFF, 12'hFFF);
        feed(OP_END_THR, 12'h000, 12'h000);
        // empty threshold burst carries the pair over
        feed(OP_END_THR, 12'h555, 12'hAAA);
        // smallest step wins, mid-scale bit flips
        feed(OP_SAMPLE, 12'h800, 12'h7FF);
        feed(OP_SAMPLE, 12'h802, 12'h7F8);
        feed(OP_SAMPLE, 12'h801, 12'h7F9);
        feed(OP_END_NOTH, 12'h000, 12'h000);
        // enough ends to run out the countdown and wrap the ring slot
        for (int k = 0; k < 7; k++) feed(OP_END_THR, 12'h000, 12'h000);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_setting(CFG_INVERT_X, FLIP_X_BY_PHASE[p]);
            write_setting(CFG_INVERT_Y, FLIP_Y_BY_PHASE[p]);
            idle_on = (p != BUSY_PHASE);
            @(negedge i_clk);
            queue_phase(PHASE_ITEMS);
            settle();
        end

        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
rtl/tmdsp_pkg.sv
rtl/touch_min_delta_sample_picker_unit.sv
test/tb_top.sv
